[sv/gstp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gstp_pkg: shared types and constants of the septet text packer
// Character map to GSM default alphabet septets and the octet bundle format
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package gstp_pkg;

    localparam int SEPT_W   = 7;
    localparam int OCTET_W  = 8;
    localparam int COUNT_W  = 10;
    localparam int BUNDLE_N = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    // septet codes
    localparam logic [SEPT_W-1:0] SEPT_ESC        = 7'h1B;
    localparam logic [SEPT_W-1:0] SEPT_DOLLAR     = 7'h02;
    localparam logic [SEPT_W-1:0] SEPT_UNDERSCORE = 7'h11;
    localparam logic [SEPT_W-1:0] SEPT_AT         = 7'h00;

    // input character codes
    localparam logic [SEPT_W-1:0] CH_AT          = 7'h40;
    localparam logic [SEPT_W-1:0] CH_DOLLAR      = 7'h24;
    localparam logic [SEPT_W-1:0] CH_UNDERSCORE  = 7'h5F;
    localparam logic [SEPT_W-1:0] CH_FORM_FEED   = 7'h0C;
    localparam logic [SEPT_W-1:0] CH_LBRACKET    = 7'h5B;
    localparam logic [SEPT_W-1:0] CH_BACKSLASH   = 7'h5C;
    localparam logic [SEPT_W-1:0] CH_RBRACKET    = 7'h5D;
    localparam logic [SEPT_W-1:0] CH_CARET       = 7'h5E;
    localparam logic [SEPT_W-1:0] CH_LBRACE      = 7'h7B;
    localparam logic [SEPT_W-1:0] CH_PIPE        = 7'h7C;
    localparam logic [SEPT_W-1:0] CH_RBRACE      = 7'h7D;
    localparam logic [SEPT_W-1:0] CH_TILDE       = 7'h7E;

    // extension table codes
    localparam logic [SEPT_W-1:0] EXT_FORM_FEED  = 7'h0A;
    localparam logic [SEPT_W-1:0] EXT_LBRACKET   = 7'h3C;
    localparam logic [SEPT_W-1:0] EXT_BACKSLASH  = 7'h2F;
    localparam logic [SEPT_W-1:0] EXT_RBRACKET   = 7'h3E;
    localparam logic [SEPT_W-1:0] EXT_CARET      = 7'h14;
    localparam logic [SEPT_W-1:0] EXT_LBRACE     = 7'h28;
    localparam logic [SEPT_W-1:0] EXT_PIPE       = 7'h40;
    localparam logic [SEPT_W-1:0] EXT_RBRACE     = 7'h29;
    localparam logic [SEPT_W-1:0] EXT_TILDE      = 7'h3D;

    typedef struct packed {
        logic              two;
        logic [SEPT_W-1:0] s0;
        logic [SEPT_W-1:0] s1;
    } map_t;

    // octets produced by one character, oldest in slot 0
    typedef struct packed {
        logic [BUNDLE_N-1:0][OCTET_W-1:0] octets;
        logic [1:0]                       n_octets;
        logic                             last;
        logic [COUNT_W-1:0]               count;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } bundle_chan_t;

    function automatic map_t map_char(input logic [SEPT_W-1:0] c, input logic prior_esc);
        map_t m;
        m.two = 1'b1;
        m.s0  = SEPT_ESC;
        m.s1  = '0;
        case (c)
            CH_FORM_FEED: m.s1 = EXT_FORM_FEED;
            CH_LBRACKET:  m.s1 = EXT_LBRACKET;
            CH_BACKSLASH: m.s1 = EXT_BACKSLASH;
            CH_RBRACKET:  m.s1 = EXT_RBRACKET;
            CH_CARET:     m.s1 = EXT_CARET;
            CH_LBRACE:    m.s1 = EXT_LBRACE;
            CH_PIPE:      m.s1 = EXT_PIPE;
            CH_RBRACE:    m.s1 = EXT_RBRACE;
            CH_TILDE:     m.s1 = EXT_TILDE;
            default:
            begin
                m.two = 1'b0;
                if (c == CH_DOLLAR)
                    m.s0 = SEPT_DOLLAR;
                else if (c == CH_UNDERSCORE)
                    m.s0 = SEPT_UNDERSCORE;
                else if (c == CH_AT && !prior_esc)
                    m.s0 = SEPT_AT;
                else
                    m.s0 = c;
            end
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

[sv/gstp_char_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gstp_char_if: character channel
// One text character per transaction with its end of message flag.
// ----------------------------------------------------------------------------
interface gstp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

[sv/gstp_octet_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gstp_octet_if: packed octet channel
// One octet per transaction; the final octet carries the septet count.
// ----------------------------------------------------------------------------
interface gstp_octet_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_octet;
    logic       last_octet;
    logic [9:0] septet_count;

    modport source (output valid, output packed_octet, output last_octet,
                    output septet_count, input ready);
    modport sink   (input valid, input packed_octet, input last_octet,
                    input septet_count, output ready);
endinterface
`default_nettype wire

[sv/gstp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gstp_front: character mapping and bit packing
// Maps each character to one or two septets, appends them to the bit
// residue and queues each full octet, plus the partial one at end of message.
// ----------------------------------------------------------------------------
module gstp_front
    import gstp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gstp_char_if.sink   char_in,
    input  wire logic   q_full,
    output bundle_chan_t push
);

    logic [SEPT_W-1:0]  residue_reg, residue_next;
    logic [2:0]         bits_reg, bits_next;
    logic               prior_esc_reg, prior_esc_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    map_t               m;
    logic [20:0]        acc;
    logic [4:0]         total;
    logic [1:0]         n_full;
    logic [2:0]         rem;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_sat;
    logic [1:0]         n_out;
    logic               accept;

    assign char_in.ready = !q_full;
    assign accept        = char_in.valid && char_in.ready;

    // septet mapping and packing of one character
    always_comb
    begin
        m      = map_char(char_in.char_code[6:0], prior_esc_reg);
        acc    = {14'd0, residue_reg}
               | ({14'd0, m.s0} << bits_reg)
               | ({14'd0, m.s1} << (4'({1'b0, bits_reg}) + 4'd7));
        total  = {2'b00, bits_reg} + (m.two ? 5'd14 : 5'd7);
        n_full = total[4:3];
        rem    = total[2:0];
        n_out  = n_full + ((char_in.end_of_text && rem != 3'd0) ? 2'd1 : 2'd0);
        count_sum = {1'b0, count_reg} + (m.two ? 11'd2 : 11'd1);
        count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];
    end

    // bundle toward the queue
    always_comb
    begin
        push.valid            = accept && (n_out != 2'd0);
        push.data.octets      = {3'b000, acc};
        push.data.n_octets    = n_out;
        push.data.last        = char_in.end_of_text;
        push.data.count       = char_in.end_of_text ? count_sat : '0;
    end

    // packing state update
    always_comb
    begin
        residue_next   = residue_reg;
        bits_next      = bits_reg;
        prior_esc_next = prior_esc_reg;
        count_next     = count_reg;
        if (accept)
        begin
            if (char_in.end_of_text)
            begin
                residue_next   = '0;
                bits_next      = '0;
                prior_esc_next = 1'b0;
                count_next     = '0;
            end
            else
            begin
                case (n_full)
                    2'd0:    residue_next = acc[6:0];
                    2'd1:    residue_next = acc[14:8];
                    2'd2:    residue_next = {2'b00, acc[20:16]};
                    default: residue_next = '0;
                endcase
                bits_next      = rem;
                prior_esc_next = !m.two && (m.s0 == SEPT_ESC);
                count_next     = count_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_reg   <= '0;
            bits_reg      <= '0;
            prior_esc_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            residue_reg   <= residue_next;
            bits_reg      <= bits_next;
            prior_esc_reg <= prior_esc_next;
            count_reg     <= count_next;
        end
    end

`ifndef SYNTHESIS
    // end of message returns the packing state to zero
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && char_in.end_of_text |=> bits_reg == 3'd0 && count_reg == '0)
        else $error("packing state not cleared after end of message");

    // the final character always yields at least one octet
    a_eot_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && char_in.end_of_text |-> push.valid)
        else $error("end of message produced no octet");

    // unused residue bits stay zero
    a_residue_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (residue_reg >> bits_reg) == '0)
        else $error("residue holds bits above its fill level");
`endif

endmodule
`default_nettype wire

[sv/gstp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gstp_queue: two-entry bundle queue
// Decouples the packing front end from the octet serializer.
// ----------------------------------------------------------------------------
module gstp_queue
    import gstp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  bundle_chan_t      push,
    input  wire logic         pop,
    output logic              full,
    output logic              empty,
    output bundle_t           head
);

    bundle_t    entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_pop;

    assign full   = (fill_reg == 2'd2);
    assign empty  = (fill_reg == 2'd0);
    assign head   = entries_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = push.valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + (push.valid ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("push into full queue");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill level out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 || fill_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill level");
`endif

endmodule
`default_nettype wire

[sv/gstp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gstp_back: octet serializer
// Sends the octets of the head bundle one per transaction through a
// registered output stage.
// ----------------------------------------------------------------------------
module gstp_back
    import gstp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     empty,
    input  bundle_t       head,
    output logic          pop,
    gstp_octet_if.source  octet_out
);

    logic               valid_reg, valid_next;
    logic [OCTET_W-1:0] octet_reg;
    logic               last_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [1:0]         idx_reg, idx_next;
    logic               load;
    logic               final_slot;

    assign octet_out.valid        = valid_reg;
    assign octet_out.packed_octet = octet_reg;
    assign octet_out.last_octet   = last_reg;
    assign octet_out.septet_count = count_reg;

    // load the output stage when it is free or being emptied
    always_comb
    begin
        load       = !empty && (!valid_reg || octet_out.ready);
        final_slot = (idx_reg == 2'(head.n_octets - 2'd1));
        pop        = load && final_slot;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = final_slot ? 2'd0 : idx_reg + 2'd1;
        end
        else if (octet_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            octet_reg <= head.octets[idx_reg];
            last_reg  <= head.last && final_slot;
            count_reg <= (head.last && final_slot) ? head.count : '0;
        end
    end

`ifndef SYNTHESIS
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> count_reg != '0)
        else $error("final octet without septet count");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |-> count_reg == '0)
        else $error("septet count on a non-final octet");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> idx_reg < head.n_octets)
        else $error("octet index beyond bundle size");
`endif

endmodule
`default_nettype wire

[sv/gsm_septet_text_packer.sv]
`timescale 1ns / 1ps
`default_nettype none
// A character's octets pass through the bundle queue and then the registered output stage.
// Throughput: one octet per cycle at the output stage while the receiver is ready; a
// character needs 0 to 3 octets, about one per plain character and two for an escaped one.
// The front end takes a character every cycle while the two-entry queue has room.
// Reset: rst_n clears residue, count, escape flag, queue and output stage at once.
// ----------------------------------------------------------------------------
// gsm_septet_text_packer: GSM 7-bit default alphabet text packer
// Maps characters to septets, packs them LSB first into octets and marks the
// final octet of a message with the saturating septet count.
// ----------------------------------------------------------------------------
module gsm_septet_text_packer
    import gstp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gstp_char_if.sink     char_in,
    gstp_octet_if.source  octet_out
);

    bundle_chan_t push;
    bundle_t      head;
    logic         q_full;
    logic         q_empty;
    logic         pop;

    // character mapping and packing
    gstp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .q_full  (q_full),
        .push    (push)
    );

    // bundle queue
    gstp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (head)
    );

    // octet serializer
    gstp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .octet_out (octet_out)
    );

endmodule
`default_nettype wire

[verif/gsm_septet_text_packer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_septet_text_packer_tb: self-checking bench of the septet text packer
// A queue of text characters feeds a clocked driver on the character channel.
// A bit-level packer model predicts every octet, and a clocked monitor on the
// octet channel compares each received octet with the oldest prediction.
// Both sides idle at random. A long receiver stall backs up the block, and a
// sender pause drains it. One longer message of escaped characters keeps the
// block producing one or two octets per character.
// ----------------------------------------------------------------------------
module gsm_septet_text_packer_tb;
    import gstp_pkg::*;

    localparam int IDLE_PCT          = 18;
    localparam int STALL_AFTER_CHARS = 60;
    localparam int STALL_CYCLES      = 80;
    localparam int CALM_FROM         = 100;
    localparam int CALM_TO           = 140;
    localparam int LONG_MSG_CHARS    = 40;
    localparam int RANDOM_CHARS      = 100;
    localparam int SETTLE_CYCLES     = 20;
    localparam int QUIET_LIMIT       = 2000;

    typedef struct {
        logic [7:0] code;
        logic       eot;
        logic       drain;
    } text_char_t;

    typedef struct packed {
        logic [7:0]         octet;
        logic               last;
        logic [COUNT_W-1:0] count;
    } packed_octet_t;

    logic clk;
    logic rst_n;

    gstp_char_if  chr ();
    gstp_octet_if oct ();

    gsm_septet_text_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (chr),
        .octet_out (oct)
    );

    // characters that travel as escape plus extension code
    logic [SEPT_W-1:0] esc_in [9] = '{CH_FORM_FEED, CH_LBRACKET, CH_BACKSLASH, CH_RBRACKET,
                                      CH_CARET, CH_LBRACE, CH_PIPE, CH_RBRACE, CH_TILDE};
    logic [SEPT_W-1:0] esc_out [9] = '{EXT_FORM_FEED, EXT_LBRACKET, EXT_BACKSLASH,
                                       EXT_RBRACKET, EXT_CARET, EXT_LBRACE, EXT_PIPE,
                                       EXT_RBRACE, EXT_TILDE};

    text_char_t    char_queue [$];
    packed_octet_t octets_due [$];
    text_char_t    next_char;
    packed_octet_t due_octet;
    packed_octet_t got_octet;

    // packer model state
    logic [SEPT_W-1:0]  pend_bits;
    int                 pend_cnt;
    logic               after_esc;
    logic [COUNT_W-1:0] sept_total;

    int  chars_taken;
    int  octets_seen;
    int  msgs_done;
    int  saturated_msgs;
    int  errors;
    int  quiet_cycles;
    int  stall_left;
    bit  stall_done;
    logic calm;

    assign calm = (chars_taken >= CALM_FROM) && (chars_taken < CALM_TO);

    // model of one accepted character: appends the octets it completes
    function automatic void pack_char(input logic [7:0] raw, input logic eot);
        logic [SEPT_W-1:0] c;
        logic [SEPT_W-1:0] sept [2];
        logic [15:0]       acc;
        int                n_sept;
        int                bits;
        int                first_new;
        packed_octet_t     fresh;
        c = raw[SEPT_W-1:0];
        n_sept = 1;
        if (c == CH_DOLLAR)
            sept[0] = SEPT_DOLLAR;
        else if (c == CH_UNDERSCORE)
            sept[0] = SEPT_UNDERSCORE;
        else if (c == CH_AT && !after_esc)
            sept[0] = SEPT_AT;
        else
            sept[0] = c;
        for (int k = 0; k < 9; k++)
        begin
            if (c == esc_in[k])
            begin
                n_sept = 2;
                sept[0] = SEPT_ESC;
                sept[1] = esc_out[k];
            end
        end

        // append septets LSB first, emit each full octet
        first_new = octets_due.size();
        acc = {9'd0, pend_bits};
        bits = pend_cnt;
        for (int i = 0; i < n_sept; i++)
        begin
            acc = acc | (16'(sept[i]) << bits);
            bits += SEPT_W;
            if (sept_total != COUNT_MAX)
                sept_total++;
            after_esc = (sept[i] == SEPT_ESC);
            while (bits >= OCTET_W)
            begin
                fresh = '{acc[7:0], 1'b0, '0};
                octets_due.insert(octets_due.size(), fresh);
                acc = acc >> OCTET_W;
                bits -= OCTET_W;
            end
        end

        if (eot)
        begin
            // flush leftover bits, tag the final octet with the count
            if (bits > 0)
            begin
                fresh = '{acc[7:0], 1'b0, '0};
                octets_due.insert(octets_due.size(), fresh);
            end
            if (octets_due.size() > first_new)
            begin
                octets_due[octets_due.size() - 1].last = 1'b1;
                octets_due[octets_due.size() - 1].count = sept_total;
            end
            if (sept_total == COUNT_MAX)
                saturated_msgs++;
            msgs_done++;
            pend_bits = '0;
            pend_cnt = 0;
            after_esc = 1'b0;
            sept_total = '0;
        end
        else
        begin
            pend_bits = acc[SEPT_W-1:0];
            pend_cnt = bits;
        end
    endfunction

    function automatic void queue_char(input logic [7:0] code, input logic eot,
                                       input logic drain);
        text_char_t t;
        t.code = code;
        t.eot = eot;
        t.drain = drain;
        char_queue.insert(char_queue.size(), t);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // character driver, model update on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr.valid <= 1'b0;
            chr.char_code <= '0;
            chr.end_of_text <= 1'b0;
        end
        else
        begin
            if (chr.valid && chr.ready)
            begin
                pack_char(chr.char_code, chr.end_of_text);
                chars_taken++;
            end
            if (!chr.valid || chr.ready)
            begin
                if (char_queue.size() > 0 &&
                    (!char_queue[0].drain || octets_due.size() == 0) &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_char = char_queue.pop_front();
                    chr.valid <= 1'b1;
                    chr.char_code <= next_char.code;
                    chr.end_of_text <= next_char.eot;
                end
                else
                    chr.valid <= 1'b0;
            end
        end
    end

    // octet receiver readiness, with one long stall once the block is busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct.ready <= 1'b0;
            stall_left = 0;
            stall_done = 1'b0;
        end
        else if (!stall_done && chars_taken >= STALL_AFTER_CHARS)
        begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            oct.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            oct.ready <= 1'b0;
        end
        else
            oct.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // octet monitor
    always @(posedge clk)
    begin
        if (rst_n && oct.valid && oct.ready)
        begin
            octets_seen++;
            got_octet = '{oct.packed_octet, oct.last_octet, oct.septet_count};
            if (octets_due.size() == 0)
            begin
                errors++;
                $display("%0t: octet with nothing expected: octet %h last %b count %0d",
                         $time, got_octet.octet, got_octet.last, got_octet.count);
            end
            else
            begin
                due_octet = octets_due.pop_front();
                if (got_octet != due_octet)
                begin
                    errors++;
                    $display({"%0t: expected octet %h last %b count %0d, ",
                              "got octet %h last %b count %0d"},
                             $time, due_octet.octet, due_octet.last, due_octet.count,
                             got_octet.octet, got_octet.last, got_octet.count);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chr.valid && chr.ready) || (oct.valid && oct.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles, %0d octets outstanding",
                             $time, QUIET_LIMIT, octets_due.size());
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int  sent;
        int  len;
        int  pick;
        bit  drain_set;
        logic [SEPT_W-1:0] ch;

        rst_n = 1'b0;
        chr.valid = 1'b0;
        chr.char_code = '0;
        chr.end_of_text = 1'b0;
        oct.ready = 1'b0;
        pend_bits = '0;
        pend_cnt = 0;
        after_esc = 1'b0;
        sept_total = '0;
        chars_taken = 0;
        octets_seen = 0;
        msgs_done = 0;
        saturated_msgs = 0;
        errors = 0;
        quiet_cycles = 0;

        // directed: '@' at message start, dollar, underscore, all escaped characters
        queue_char({1'b0, CH_AT}, 1'b0, 1'b0);
        queue_char({1'b0, CH_DOLLAR}, 1'b0, 1'b0);
        queue_char({1'b1, CH_UNDERSCORE}, 1'b0, 1'b0);
        for (int k = 0; k < 9; k++)
            queue_char({k[0], esc_in[k]}, 1'b0, 1'b0);
        // '@' after an extension code, then raw escape followed by '@' with bit 7 set
        queue_char({1'b0, CH_AT}, 1'b0, 1'b0);
        queue_char({1'b0, SEPT_ESC}, 1'b0, 1'b0);
        queue_char({1'b1, CH_AT}, 1'b0, 1'b0);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char(8'h80, 1'b0, 1'b0);
        queue_char(8'h7F, 1'b1, 1'b0);
        // one character message
        queue_char(8'h78, 1'b1, 1'b0);
        // eight septets end exactly on an octet boundary
        for (int k = 0; k < 8; k++)
            queue_char(8'($urandom_range(8'h41, 8'h5A)), k == 7, 1'b0);

        // longer escaped message; sender drains first
        for (int k = 0; k < LONG_MSG_CHARS; k++)
            queue_char({1'($urandom_range(0, 1)), esc_in[$urandom_range(0, 8)]},
                       k == LONG_MSG_CHARS - 1, k == 0);

        // random messages of short length
        sent = 0;
        drain_set = 1'b0;
        while (sent < RANDOM_CHARS)
        begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len && sent < RANDOM_CHARS; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    ch = esc_in[$urandom_range(0, 8)];
                else if (pick < 45)
                    ch = CH_AT;
                else if (pick < 52)
                    ch = SEPT_ESC;
                else if (pick < 58)
                    ch = $urandom_range(0, 1) ? CH_DOLLAR : CH_UNDERSCORE;
                else
                    ch = 7'($urandom_range(0, 127));
                queue_char({1'($urandom_range(0, 1)), ch},
                           (j == len - 1) || (sent == RANDOM_CHARS - 1),
                           j == 0 && sent >= RANDOM_CHARS / 2 && !drain_set);
                if (j == 0 && sent >= RANDOM_CHARS / 2)
                    drain_set = 1'b1;
                sent++;
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_queue.size() != 0 || chr.valid)
            @(posedge clk);
        while (octets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d characters in %0d messages, %0d octets checked",
                 chars_taken, msgs_done, octets_seen);
        $display("%0d message(s) reached the saturated septet count, %0d mismatch(es)",
                 saturated_msgs, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
